FILE: rtl/fmcf_pkg.sv
// shared types and constants for the functional map cycle finder
// no dependencies; used by functional_map_cycle_finder_top, cycle_key_checker and tb_top
`default_nettype none

package fmcf_pkg;

    localparam int KEYS   = 16;
    localparam int KEY_W  = $clog2(KEYS);
    localparam int STEP_W = $clog2(KEYS + 1);

    // operation codes of an input transaction; the fourth code is ignored
    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EVAL   = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] entry_key;
        logic [KEY_W-1:0] entry_value;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] cyclic_key;
        logic             none_found;
        logic             last_result;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_STEP,
        ST_PUSH,
        ST_NEXT,
        ST_FINISH
    } fsm_state_t;

endpackage

`default_nettype wire

FILE: rtl/fmcf_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module fmcf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/functional_map_cycle_finder_top.sv
// top level of the functional map cycle finder: control, valid bits, output register
// depends on fmcf_pkg and fmcf_ram
//
//   channel  | dir | payload   | handshake
//   ---------+-----+-----------+-------------------------------------
//   item     | in  | item_t    | item_valid / item_stall
//   result   | out | result_t  | result_valid / result_stall
//
// set and remove transactions are applied in idle, and the block stays idle
// an evaluate walks each start key one step per cycle through the successor ram
// (registered read feeds the next address directly) until it meets an unmapped
// key or has passed enough mapped checks to prove a cycle
// reset clears the mapped bits at once; the successor ram needs no clearing pass
// items are taken only while idle; result stalls hold the walk at the next emit
`default_nettype none

module functional_map_cycle_finder_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire fmcf_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output fmcf_pkg::result_t      result
);

    import fmcf_pkg::*;

    fsm_state_t        state_reg, state_next;
    logic [KEYS-1:0]   mapped_reg, mapped_next;
    logic [KEY_W-1:0]  key_reg, key_next;      // start key of the current walk
    logic [STEP_W-1:0] step_reg, step_next;    // mapped checks passed so far
    logic [KEY_W-1:0]  pend_reg, pend_next;    // last cyclic key not yet emitted
    logic              pend_valid_reg, pend_valid_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              item_accept;
    logic              out_free;
    logic [KEY_W-1:0]  walk_key;
    logic              walk_hit;
    logic              ram_wr_en;
    logic [KEY_W-1:0]  ram_rd_data;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // output slot can take a new transaction this cycle
    assign out_free = !result_valid_reg || !result_stall;

    // walk address: the start key on entry, otherwise the successor just read
    assign walk_key = (state_reg == ST_START) ? key_reg : ram_rd_data;
    assign walk_hit = mapped_reg[walk_key];

    // writes happen only in idle and read data is used only during a walk, so no read
    // that the walk uses overlaps a write to the same entry of the single ram
    assign ram_wr_en = item_accept && (item.operation == OP_SET);

    fmcf_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEYS)
    ) u_successor_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (item.entry_key),
        .wr_data (item.entry_value),
        .rd_addr (walk_key),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && (item.operation == OP_EVAL))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = walk_hit ? ST_STEP : ST_NEXT;
            end
            ST_STEP:
            begin
                if (!walk_hit)
                begin
                    state_next = ST_NEXT;
                end
                else if (step_reg == STEP_W'(KEYS))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                state_next = (key_reg == KEY_W'(KEYS - 1)) ? ST_FINISH : ST_START;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mapped_next       = mapped_reg;
        key_next          = key_reg;
        step_next         = step_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (item.operation)
                        OP_SET:    mapped_next[item.entry_key] = 1'b1;
                        OP_REMOVE: mapped_next[item.entry_key] = 1'b0;
                        OP_EVAL:
                        begin
                            key_next        = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START:
            begin
                step_next = STEP_W'(1);
            end
            ST_STEP:
            begin
                step_next = step_reg + 1'b1;
            end
            ST_PUSH:
            begin
                // the previous cyclic key is known not to be last now
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next      = 1'b1;
                        result_next.cyclic_key  = pend_reg;
                        result_next.none_found  = 1'b0;
                        result_next.last_result = 1'b0;
                    end
                    pend_next       = key_reg;
                    pend_valid_next = 1'b1;
                end
            end
            ST_NEXT:
            begin
                key_next = key_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next       = 1'b1;
                    result_next.cyclic_key  = pend_valid_reg ? pend_reg : '0;
                    result_next.none_found  = !pend_valid_reg;
                    result_next.last_result = 1'b1;
                    pend_valid_next         = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mapped_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mapped_reg       <= mapped_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        step_reg   <= step_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    // an evaluate transaction always starts a walk on the next cycle
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && (item.operation == OP_EVAL) |=> state_reg == ST_START)
        else $error("evaluate did not start a walk");

    // a walk step always follows at least one passed mapped check
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> step_reg != '0)
        else $error("walk step with zero passed checks");

    // no held cyclic key survives past the end of an evaluation
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending key left over in idle");

    // a none result is the only and therefore last result, with key zero
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.none_found |->
            result_reg.last_result && (result_reg.cyclic_key == '0))
        else $error("malformed none result");

endmodule

`default_nettype wire

FILE: bench/cycle_key_checker.sv
`timescale 1ns / 100ps
// checker for the functional map cycle finder: watches both channels, predicts
// the cyclic keys of each evaluate and compares them; depends on fmcf_pkg
module cycle_key_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire fmcf_pkg::item_t   item,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire fmcf_pkg::result_t result,
    output int                     mismatches,
    output int                     outstanding
);

    import fmcf_pkg::*;

    // own copy of the map
    logic [KEY_W-1:0] next_key [KEYS];
    bit               mapped   [KEYS];

    result_t cyclic_keys_due[$];
    int      fail_count;

    // still mapped after KEYS steps means the sequence repeats
    function automatic bit key_is_cyclic(int start);
        int x;
        int i;
        x = start;
        for (i = 0; i <= KEYS; i++)
        begin
            if (x >= KEYS || !mapped[x])
                return 1'b0;
            x = int'(next_key[x]);
        end
        return 1'b1;
    endfunction

    task automatic predict_evaluation();
        bit      loops [KEYS];
        int      last_k;
        result_t r;
        last_k = -1;
        for (int k = 0; k < KEYS; k++)
        begin
            loops[k] = key_is_cyclic(k);
            if (loops[k])
                last_k = k;
        end
        if (last_k < 0)
        begin
            r = '0;
            r.none_found  = 1'b1;
            r.last_result = 1'b1;
            cyclic_keys_due.push_back(r);
        end
        else
            for (int k = 0; k <= last_k; k++)
                if (loops[k])
                begin
                    r = '0;
                    r.cyclic_key  = KEY_W'(k);
                    r.last_result = (k == last_k);
                    cyclic_keys_due.push_back(r);
                end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                next_key[k] = '0;
                mapped[k]   = 1'b0;
            end
            cyclic_keys_due.delete();
            fail_count  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a result at this edge belongs to an earlier evaluate
            if (result_valid && !result_stall)
            begin
                if (cyclic_keys_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t unexpected result key=%0d none=%b last=%b", $realtime,
                                 result.cyclic_key, result.none_found, result.last_result);
                end
                else
                begin
                    want = cyclic_keys_due.pop_front();
                    if (result.cyclic_key !== want.cyclic_key
                        || result.none_found !== want.none_found
                        || result.last_result !== want.last_result)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t mismatch: exp %0d %b %b, got %0d %b %b",
                                     $realtime, want.cyclic_key, want.none_found,
                                     want.last_result, result.cyclic_key,
                                     result.none_found, result.last_result);
                    end
                end
            end

            if (item_valid && !item_stall)
            begin
                case (item.operation)
                    OP_SET:
                        if (int'(item.entry_key) < KEYS)
                        begin
                            next_key[item.entry_key] = item.entry_value;
                            mapped[item.entry_key]   = 1'b1;
                        end
                    OP_REMOVE:
                        if (int'(item.entry_key) < KEYS)
                            mapped[item.entry_key] = 1'b0;
                    OP_EVAL:
                        predict_evaluation();
                    default:
                        ;
                endcase
            end

            mismatches  <= fail_count;
            outstanding <= cyclic_keys_due.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the functional map cycle finder: clock, reset, stimulus, verdict
// depends on fmcf_pkg, functional_map_cycle_finder_top and cycle_key_checker
module tb_top;
    import fmcf_pkg::*;

    // the fourth operation code, which the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // about twice the length of an unstalled evaluate, so this covers any tail
    localparam int SETTLE_CYCLES = 2 * KEYS * (KEYS + 3);
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEMS_PER_PHASE = 70;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int mismatches;
    int outstanding;
    int cycles = 0;

    // idling controls, changed between phases
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // counts random transactions that the block acts on
    int acted_items = 0;
    bit counting = 1'b0;

    int key_order [KEYS];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    functional_map_cycle_finder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    cycle_key_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // receiver side: random stall per cycle, independent of result_valid
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one transaction on the item channel; returns right after the accepting edge
    task automatic issue_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                              input logic [KEY_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid       <= 1'b1;
        item.operation   <= op;
        item.entry_key   <= key;
        item.entry_value <= val;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (counting && op != OP_UNUSED)
            acted_items++;
    endtask

    task automatic evaluate();
        // key and value are don't-care here, so randomize them for bit coverage
        issue_item(OP_EVAL, KEY_W'($urandom), KEY_W'($urandom));
    endtask

    // hold off the sender until every expected result has come back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic shuffle_keys();
        int j;
        int t;
        for (int i = 0; i < KEYS; i++)
            key_order[i] = i;
        for (int i = KEYS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = key_order[i];
            key_order[i] = key_order[j];
            key_order[j] = t;
        end
    endtask

    // well-formed run: a loop over distinct keys, a few chains, sometimes a break
    task automatic loop_scenario();
        int len;
        int tails;
        len = ($urandom_range(9) == 0) ? KEYS : $urandom_range(1, 5);
        tails = $urandom_range(0, 3);
        shuffle_keys();
        for (int i = 0; i < len; i++)
            issue_item(OP_SET, KEY_W'(key_order[i]), KEY_W'(key_order[(i + 1) % len]));
        for (int i = 0; i < tails && len + i < KEYS; i++)
            // tail either feeds into the loop or points anywhere
            issue_item(OP_SET, KEY_W'(key_order[len + i]),
                       $urandom_range(1) ? KEY_W'(key_order[$urandom_range(len - 1)])
                                         : KEY_W'($urandom));
        if ($urandom_range(3) == 0)
            issue_item(OP_REMOVE, KEY_W'(key_order[$urandom_range(len - 1)]), KEY_W'($urandom));
        evaluate();
    endtask

    // empty the whole map, then evaluate: expect the none-found answer
    task automatic clear_scenario();
        shuffle_keys();
        for (int i = 0; i < KEYS; i++)
            issue_item(OP_REMOVE, KEY_W'(key_order[i]), KEY_W'($urandom));
        evaluate();
    endtask

    // noise: any operation code, any fields
    task automatic noise_scenario();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            issue_item(2'($urandom_range(3)), KEY_W'($urandom), KEY_W'($urandom));
        if ($urandom_range(1))
            evaluate();
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int r;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (acted_items < ITEMS_PER_PHASE)
        begin
            r = $urandom_range(99);
            if (r < 60)
                loop_scenario();
            else if (r < 68)
                clear_scenario();
            else
                noise_scenario();
        end
        acted_items = 0;
        // sender pause until everything is back before the idling changes
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty map gives the none-found answer
        evaluate();
        // self loops at both key extremes, a two-key loop, a chain to an unmapped
        // key, and a chain that runs into a loop
        issue_item(OP_SET, KEY_W'(0), KEY_W'(0));
        issue_item(OP_SET, KEY_W'(KEYS - 1), KEY_W'(KEYS - 1));
        issue_item(OP_SET, KEY_W'(5), KEY_W'(6));
        issue_item(OP_SET, KEY_W'(6), KEY_W'(5));
        issue_item(OP_SET, KEY_W'(7), KEY_W'(8));
        issue_item(OP_SET, KEY_W'(9), KEY_W'(5));
        issue_item(OP_SET, KEY_W'(10), KEY_W'(7));
        evaluate();
        // unused code must leave the map alone
        issue_item(OP_UNUSED, KEY_W'(KEYS - 1), KEY_W'(3));
        issue_item(OP_UNUSED, KEY_W'(0), KEY_W'(KEYS - 1));
        evaluate();
        // overwrite a successor, then break the loops
        issue_item(OP_SET, KEY_W'(0), KEY_W'(KEYS - 1));
        issue_item(OP_REMOVE, KEY_W'(KEYS - 1), KEY_W'(0));
        evaluate();
        issue_item(OP_REMOVE, KEY_W'(5), KEY_W'(KEYS - 1));
        issue_item(OP_REMOVE, KEY_W'(0), KEY_W'(0));
        evaluate();
        // removing an unmapped key is harmless
        issue_item(OP_REMOVE, KEY_W'(12), KEY_W'(9));
        issue_item(OP_SET, KEY_W'(5), KEY_W'(9));
        evaluate();
        drain();

        counting = 1'b1;
        random_phase(0, 0);
        random_phase(57, 0);
        random_phase(0, 57);
        random_phase(14, 14);

        // final tail: nothing more should come out
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fmcf_pkg.sv
rtl/fmcf_ram.sv
rtl/functional_map_cycle_finder_top.sv
bench/cycle_key_checker.sv
bench/tb_top.sv
